### hw/rtl/dfa_pkg.sv
// Shared types, constants and helpers of the decimal floating-point arithmetic unit.
package dfa_pkg;

  localparam logic signed [15:0] MaxExp   = 16'sd999;
  localparam logic signed [15:0] InfExp   = 16'sd1000;
  localparam logic signed [15:0] NanExp   = 16'sd2000;
  localparam logic signed [16:0] AlignGap = 17'sd40;
  localparam logic [63:0]        TenthMax = 64'h1999_9999_9999_9999;
  localparam logic [63:0]        Ten      = 64'd10;
  localparam logic [63:0]        Five     = 64'd5;
  localparam int                 IterSteps = 64;
  localparam int                 CntW      = $clog2(IterSteps);

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_CMP = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CMP_LT = 2'd0,
    CMP_EQ = 2'd1,
    CMP_GT = 2'd2,
    CMP_UN = 2'd3
  } cmp_e;

  typedef enum logic {
    IU_MUL = 1'b0,
    IU_DIV = 1'b1
  } iu_op_e;

  typedef struct packed {
    logic [2:0]         kind;
    logic               a_sign;
    logic               a_inexact;
    logic signed [15:0] a_exp;
    logic [63:0]        a_mant;
    logic               b_sign;
    logic               b_inexact;
    logic signed [15:0] b_exp;
    logic [63:0]        b_mant;
  } dfa_in_t;

  typedef struct packed {
    logic               res_sign;
    logic               res_inexact;
    logic signed [15:0] res_exp;
    logic [63:0]        res_mant;
    logic [1:0]         cmp_code;
  } dfa_out_t;

  typedef struct packed {
    logic               sign;
    logic               inx;
    logic signed [15:0] e;
    logic [63:0]        m;
  } dnum_t;

  typedef struct packed {
    logic        start;
    iu_op_e      op;
    logic [63:0] a;
    logic [63:0] b;
  } iu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] lo;
    logic [63:0] hi;
  } iu_rsp_t;

  function automatic logic is_special(logic signed [15:0] e);
    return $signed(e) > $signed(MaxExp);
  endfunction

  function automatic logic [63:0] times_ten(logic [63:0] m);
    return (m << 3) + (m << 1);
  endfunction

endpackage

### hw/rtl/dfa_chan_if.sv
// Valid/ready channel carrying one transaction payload.
interface dfa_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/decimal_float_arith_unit_top.sv
// Top level of the decimal floating-point arithmetic unit with channel ports.
// One transaction at a time. Special or zero operands and the unused kinds need no pass of
// the shared unit. Otherwise each decimal digit that is divided out (trailing-zero strip, alignment
// shift, carry drop, product fit) and the final quotient or product check is one pass of the
// shared 64-step shift/add-subtract unit, while each digit of up-scaling needs no pass; an
// operation takes from no pass at all (add, subtract or compare of operands with equal
// exponents) to over a hundred passes for a multiply that strips and fits many digits.
// The result is held in an output register, and a new transaction is taken while it waits.
module decimal_float_arith_unit_top
  import dfa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  dfa_chan_if.sink   in_ch,
  dfa_chan_if.source out_ch
);

  iu_req_t  iu_req;
  iu_rsp_t  iu_rsp;
  dfa_out_t seq_res, out_q;
  logic     seq_idle, seq_done, seq_ack, start;
  logic     ov_q, ov_d;

  assign in_ch.ready = seq_idle;
  assign start       = in_ch.valid & seq_idle;
  assign seq_ack     = seq_done & (~ov_q | out_ch.ready);

  dfa_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .item_i   (in_ch.data),
    .idle_o   (seq_idle),
    .done_o   (seq_done),
    .ack_i    (seq_ack),
    .res_o    (seq_res),
    .iu_req_o (iu_req),
    .iu_rsp_i (iu_rsp)
  );

  dfa_iter_unit u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (iu_req),
    .rsp_o  (iu_rsp)
  );

  always_comb begin
    ov_d = ov_q;
    if (seq_ack) begin
      ov_d = 1'b1;
    end else if (out_ch.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_ack) begin
      out_q <= seq_res;
    end
  end

  assign out_ch.valid = ov_q;
  assign out_ch.data  = out_q;

endmodule

### hw/rtl/dfa_iter_unit.sv
// Shared 64-step shift/add unit: unsigned 64x64 multiply or 64/64 restoring divide.
module dfa_iter_unit
  import dfa_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  iu_req_t req_i,
  output iu_rsp_t rsp_o
);

  localparam logic [CntW-1:0] LastStep = CntW'(IterSteps - 1);

  logic [127:0]    p_q, p_step;
  logic [63:0]     d_q;
  iu_op_e          op_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [64:0]     base, opnd;
  logic            cin;
  logic [65:0]     sum;

  always_comb begin
    if (op_q == IU_DIV) begin
      base = p_q[127:63];
      opnd = ~{1'b0, d_q};
      cin  = 1'b1;
    end else begin
      base = {1'b0, p_q[127:64]};
      opnd = p_q[0] ? {1'b0, d_q} : 65'd0;
      cin  = 1'b0;
    end
    sum = {1'b0, base} + {1'b0, opnd} + {65'd0, cin};
    if (op_q == IU_DIV) begin
      p_step = sum[65] ? {sum[63:0], p_q[62:0], 1'b1} : {p_q[126:0], 1'b0};
    end else begin
      p_step = {sum[64:0], p_q[63:1]};
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      p_q  <= {64'd0, req_i.a};
      d_q  <= req_i.b;
      op_q <= req_i.op;
    end else if (busy_q) begin
      p_q <= p_step;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.lo   = p_q[63:0];
  assign rsp_o.hi   = p_q[127:64];

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("unit restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without a run");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held");

endmodule

### hw/rtl/dfa_seq.sv
// Sequencer: operand handling, alignment and normalization steps over the shared unit.
module dfa_seq
  import dfa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dfa_in_t  item_i,
  output logic     idle_o,
  output logic     done_o,
  input  logic     ack_i,
  output dfa_out_t res_o,
  output iu_req_t  iu_req_o,
  input  iu_rsp_t  iu_rsp_i
);

  typedef enum logic [24:0] {
    S_IDLE      = 25'h0000001,
    S_AL_CHK    = 25'h0000002,
    S_AL_L1     = 25'h0000004,
    S_AL_L1W    = 25'h0000008,
    S_AL_L2     = 25'h0000010,
    S_AL_L3W    = 25'h0000020,
    S_ADD_FIN   = 25'h0000040,
    S_ADD_DIVL  = 25'h0000080,
    S_ADD_DIVR  = 25'h0000100,
    S_SUB_FIN   = 25'h0000200,
    S_CMP_FIN   = 25'h0000400,
    S_MUL_L10W  = 25'h0000800,
    S_MUL_R10W  = 25'h0001000,
    S_MUL_F5L   = 25'h0002000,
    S_MUL_F5LW  = 25'h0004000,
    S_MUL_F5R   = 25'h0008000,
    S_MUL_F5RW  = 25'h0010000,
    S_MUL_PT    = 25'h0020000,
    S_MUL_PW    = 25'h0040000,
    S_MUL_SL    = 25'h0080000,
    S_MUL_SR    = 25'h0100000,
    S_DIV_SCALE = 25'h0200000,
    S_DIV_R10W  = 25'h0400000,
    S_DIV_QW    = 25'h0800000,
    S_DONE      = 25'h1000000
  } state_e;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_CMP = 2'd2
  } mode_e;

  state_e      state_q, state_d, post_st;
  mode_e       mode_q, mode_d;
  dnum_t       x_q, x_d, y_q, y_d, res_q, res_d;
  dnum_t       da, db, a_v, b_v, a_n, b_n, cl, cr;
  cmp_e        code_q, code_d;
  logic        swp_q, swp_d, pinx_q, pinx_d;
  logic        al_wr, a_gt_b, gap_big, rem_nz;
  logic [64:0] sum65;

  always_comb begin
    da.sign = item_i.a_sign;
    da.inx  = item_i.a_inexact;
    da.e    = item_i.a_exp;
    da.m    = item_i.a_mant;
    db.sign = item_i.b_sign;
    db.inx  = item_i.b_inexact;
    db.e    = item_i.b_exp;
    db.m    = item_i.b_mant;
  end

  assign a_v     = swp_q ? y_q : x_q;
  assign b_v     = swp_q ? x_q : y_q;
  assign a_gt_b  = $signed(a_v.e) > $signed(b_v.e);
  assign gap_big = $signed({a_v.e[15], a_v.e}) > ($signed({b_v.e[15], b_v.e}) + AlignGap);
  assign rem_nz  = iu_rsp_i.hi != 64'd0;
  assign sum65   = {1'b0, x_q.m} + {1'b0, y_q.m};
  assign cl      = x_q.sign ? y_q : x_q;
  assign cr      = x_q.sign ? x_q : y_q;
  assign post_st = (mode_q == MODE_ADD) ? S_ADD_FIN :
                   (mode_q == MODE_SUB) ? S_SUB_FIN : S_CMP_FIN;

  always_comb begin
    state_d        = state_q;
    mode_d         = mode_q;
    x_d            = x_q;
    y_d            = y_q;
    swp_d          = swp_q;
    pinx_d         = pinx_q;
    res_d          = res_q;
    code_d         = code_q;
    a_n            = a_v;
    b_n            = b_v;
    al_wr          = 1'b0;
    iu_req_o.start = 1'b0;
    iu_req_o.op    = IU_DIV;
    iu_req_o.a     = x_q.m;
    iu_req_o.b     = Ten;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          res_d   = '0;
          code_d  = CMP_LT;
          x_d     = da;
          y_d     = db;
          mode_d  = MODE_ADD;
          state_d = S_DONE;
          case (item_i.kind)
            KIND_ADD, KIND_SUB: begin
              if (da.sign != db.sign) begin
                if (item_i.kind == KIND_ADD) begin
                  mode_d = MODE_SUB;
                  if (da.sign) begin
                    x_d      = db;
                    y_d      = da;
                    y_d.sign = 1'b0;
                  end else begin
                    y_d.sign = 1'b0;
                  end
                end else begin
                  mode_d   = MODE_ADD;
                  y_d.sign = da.sign;
                end
              end else begin
                mode_d = (item_i.kind == KIND_ADD) ? MODE_ADD : MODE_SUB;
              end
              if (mode_d == MODE_ADD) begin
                if (is_special(x_d.e)) begin
                  res_d = (is_special(y_d.e) && y_d.m == 64'd0) ? y_d : x_d;
                end else if (is_special(y_d.e)) begin
                  res_d = y_d;
                end else begin
                  state_d = S_AL_CHK;
                end
              end else if (is_special(x_d.e) || is_special(y_d.e)) begin
                res_d   = x_d;
                res_d.e = NanExp;
                res_d.m = 64'd0;
              end else begin
                state_d = S_AL_CHK;
              end
            end
            KIND_MUL: begin
              if (is_special(da.e) || is_special(db.e)) begin
                res_d.sign = da.sign ^ db.sign;
                res_d.m    = (da.m != 64'd0 && db.m != 64'd0) ? 64'd1 : 64'd0;
                res_d.e    = InfExp;
              end else if (da.m == 64'd0) begin
                res_d = da;
              end else if (db.m == 64'd0) begin
                res_d = db;
              end else begin
                iu_req_o.start = 1'b1;
                iu_req_o.a     = da.m;
                state_d        = S_MUL_L10W;
              end
            end
            KIND_DIV: begin
              if (is_special(da.e)) begin
                res_d   = da;
                res_d.m = 64'd0;
              end else if (is_special(db.e)) begin
                if (db.m != 64'd0) begin
                  res_d.inx = 1'b1;
                end else begin
                  res_d = db;
                end
              end else if (db.m == 64'd0) begin
                res_d.sign = da.sign ^ db.sign;
                res_d.e    = NanExp;
                res_d.inx  = 1'b1;
              end else if (da.m == 64'd0) begin
                res_d = da;
              end else begin
                state_d = S_DIV_SCALE;
              end
            end
            KIND_CMP: begin
              mode_d = MODE_CMP;
              if (is_special(da.e)) begin
                if (da.m == 64'd0) begin
                  code_d = CMP_UN;
                end else if (is_special(db.e) && (db.m == 64'd0 || db.sign == da.sign)) begin
                  code_d = CMP_UN;
                end else begin
                  code_d = da.sign ? CMP_LT : CMP_GT;
                end
              end else if (is_special(db.e)) begin
                if (db.m == 64'd0) begin
                  code_d = CMP_UN;
                end else begin
                  code_d = db.sign ? CMP_GT : CMP_LT;
                end
              end else if (da.sign != db.sign) begin
                if (da.m == 64'd0 && db.m == 64'd0) begin
                  code_d = CMP_EQ;
                end else begin
                  code_d = da.sign ? CMP_LT : CMP_GT;
                end
              end else begin
                state_d = S_AL_CHK;
              end
            end
            default: begin
              code_d = CMP_UN;
            end
          endcase
          swp_d = $signed(x_d.e) < $signed(y_d.e);
        end
      end

      S_AL_CHK: begin
        al_wr = 1'b1;
        if (b_v.m == 64'd0) begin
          b_n.e   = a_v.e;
          state_d = post_st;
        end else if (a_v.m == 64'd0) begin
          a_n.e   = b_v.e;
          state_d = post_st;
        end else if (gap_big) begin
          b_n.inx = 1'b1;
          b_n.e   = a_v.e;
          b_n.m   = 64'd0;
          state_d = post_st;
        end else begin
          state_d = S_AL_L1;
        end
      end

      S_AL_L1: begin
        if (a_gt_b) begin
          iu_req_o.start = 1'b1;
          iu_req_o.a     = b_v.m;
          state_d        = S_AL_L1W;
        end else begin
          state_d = post_st;
        end
      end

      S_AL_L1W: begin
        if (iu_rsp_i.done) begin
          if (!rem_nz) begin
            al_wr   = 1'b1;
            b_n.m   = iu_rsp_i.lo;
            b_n.e   = b_v.e + 16'sd1;
            state_d = S_AL_L1;
          end else begin
            state_d = S_AL_L2;
          end
        end
      end

      S_AL_L2: begin
        if (a_gt_b) begin
          if (a_v.m <= TenthMax) begin
            al_wr = 1'b1;
            a_n.m = times_ten(a_v.m);
            a_n.e = a_v.e - 16'sd1;
          end else begin
            iu_req_o.start = 1'b1;
            iu_req_o.a     = b_v.m;
            state_d        = S_AL_L3W;
          end
        end else begin
          state_d = post_st;
        end
      end

      S_AL_L3W: begin
        if (iu_rsp_i.done) begin
          al_wr   = 1'b1;
          b_n.m   = iu_rsp_i.lo;
          b_n.e   = b_v.e + 16'sd1;
          b_n.inx = 1'b1;
          state_d = S_AL_L2;
        end
      end

      S_ADD_FIN: begin
        if (!sum65[64]) begin
          res_d     = x_q;
          res_d.inx = x_q.inx | y_q.inx;
          res_d.m   = sum65[63:0];
          state_d   = S_DONE;
        end else begin
          x_d.inx        = x_q.inx | y_q.inx;
          iu_req_o.start = 1'b1;
          state_d        = S_ADD_DIVL;
        end
      end

      S_ADD_DIVL: begin
        if (iu_rsp_i.done) begin
          x_d.inx = x_q.inx | rem_nz;
          x_d.m   = iu_rsp_i.lo;
          x_d.e   = x_q.e + 16'sd1;
          if (is_special(x_d.e)) begin
            res_d   = x_d;
            state_d = S_DONE;
          end else begin
            iu_req_o.start = 1'b1;
            iu_req_o.a     = y_q.m;
            state_d        = S_ADD_DIVR;
          end
        end
      end

      S_ADD_DIVR: begin
        if (iu_rsp_i.done) begin
          res_d     = x_q;
          res_d.inx = x_q.inx | rem_nz;
          res_d.m   = x_q.m + iu_rsp_i.lo;
          state_d   = S_DONE;
        end
      end

      S_SUB_FIN: begin
        if (y_q.m > x_q.m) begin
          res_d      = y_q;
          res_d.sign = ~y_q.sign;
          res_d.m    = y_q.m - x_q.m;
        end else begin
          res_d   = x_q;
          res_d.m = x_q.m - y_q.m;
        end
        res_d.inx = x_q.inx | y_q.inx;
        state_d   = S_DONE;
      end

      S_CMP_FIN: begin
        if (cl.e != cr.e) begin
          code_d = ($signed(cl.e) < $signed(cr.e)) ? CMP_LT : CMP_GT;
        end else if (cl.m != cr.m) begin
          code_d = (cl.m < cr.m) ? CMP_LT : CMP_GT;
        end else begin
          code_d = CMP_EQ;
        end
        state_d = S_DONE;
      end

      S_MUL_L10W: begin
        if (iu_rsp_i.done) begin
          iu_req_o.start = 1'b1;
          if (!rem_nz) begin
            x_d.m      = iu_rsp_i.lo;
            x_d.e      = x_q.e + 16'sd1;
            iu_req_o.a = iu_rsp_i.lo;
          end else begin
            iu_req_o.a = y_q.m;
            state_d    = S_MUL_R10W;
          end
        end
      end

      S_MUL_R10W: begin
        if (iu_rsp_i.done) begin
          if (!rem_nz) begin
            y_d.m          = iu_rsp_i.lo;
            y_d.e          = y_q.e + 16'sd1;
            iu_req_o.start = 1'b1;
            iu_req_o.a     = iu_rsp_i.lo;
          end else begin
            state_d = S_MUL_F5L;
          end
        end
      end

      S_MUL_F5L: begin
        if (!y_q.m[0]) begin
          iu_req_o.start = 1'b1;
          iu_req_o.b     = Five;
          state_d        = S_MUL_F5LW;
        end else begin
          state_d = S_MUL_F5R;
        end
      end

      S_MUL_F5LW: begin
        if (iu_rsp_i.done) begin
          if (!rem_nz) begin
            x_d.m   = iu_rsp_i.lo;
            x_d.e   = x_q.e + 16'sd1;
            y_d.m   = y_q.m >> 1;
            state_d = S_MUL_F5L;
          end else begin
            state_d = S_MUL_F5R;
          end
        end
      end

      S_MUL_F5R: begin
        if (!x_q.m[0]) begin
          iu_req_o.start = 1'b1;
          iu_req_o.a     = y_q.m;
          iu_req_o.b     = Five;
          state_d        = S_MUL_F5RW;
        end else begin
          state_d = S_MUL_PT;
        end
      end

      S_MUL_F5RW: begin
        if (iu_rsp_i.done) begin
          if (!rem_nz) begin
            y_d.m   = iu_rsp_i.lo;
            y_d.e   = y_q.e + 16'sd1;
            x_d.m   = x_q.m >> 1;
            state_d = S_MUL_F5R;
          end else begin
            state_d = S_MUL_PT;
          end
        end
      end

      S_MUL_PT: begin
        pinx_d         = x_q.inx | y_q.inx;
        iu_req_o.start = 1'b1;
        iu_req_o.op    = IU_MUL;
        iu_req_o.b     = y_q.m;
        state_d        = S_MUL_PW;
      end

      S_MUL_PW: begin
        if (iu_rsp_i.done) begin
          if (iu_rsp_i.hi != 64'd0) begin
            pinx_d         = 1'b1;
            iu_req_o.start = 1'b1;
            if (x_q.m > y_q.m) begin
              state_d = S_MUL_SL;
            end else begin
              iu_req_o.a = y_q.m;
              state_d    = S_MUL_SR;
            end
          end else begin
            res_d.sign = x_q.sign ^ y_q.sign;
            res_d.inx  = pinx_q;
            res_d.e    = x_q.e + y_q.e;
            res_d.m    = iu_rsp_i.lo;
            state_d    = S_DONE;
          end
        end
      end

      S_MUL_SL: begin
        if (iu_rsp_i.done) begin
          x_d.m          = iu_rsp_i.lo;
          x_d.e          = x_q.e + 16'sd1;
          iu_req_o.start = 1'b1;
          iu_req_o.op    = IU_MUL;
          iu_req_o.a     = iu_rsp_i.lo;
          iu_req_o.b     = y_q.m;
          state_d        = S_MUL_PW;
        end
      end

      S_MUL_SR: begin
        if (iu_rsp_i.done) begin
          y_d.m          = iu_rsp_i.lo;
          y_d.e          = y_q.e + 16'sd1;
          iu_req_o.start = 1'b1;
          iu_req_o.op    = IU_MUL;
          iu_req_o.b     = iu_rsp_i.lo;
          state_d        = S_MUL_PW;
        end
      end

      S_DIV_SCALE: begin
        if (x_q.m < TenthMax) begin
          x_d.m = times_ten(x_q.m);
          x_d.e = x_q.e - 16'sd1;
        end else begin
          iu_req_o.start = 1'b1;
          iu_req_o.a     = y_q.m;
          state_d        = S_DIV_R10W;
        end
      end

      S_DIV_R10W: begin
        if (iu_rsp_i.done) begin
          iu_req_o.start = 1'b1;
          if (!rem_nz) begin
            y_d.m      = iu_rsp_i.lo;
            y_d.e      = y_q.e + 16'sd1;
            iu_req_o.a = iu_rsp_i.lo;
          end else begin
            iu_req_o.b = y_q.m;
            state_d    = S_DIV_QW;
          end
        end
      end

      S_DIV_QW: begin
        if (iu_rsp_i.done) begin
          res_d.sign = x_q.sign ^ y_q.sign;
          res_d.inx  = x_q.inx | y_q.inx | rem_nz;
          res_d.e    = x_q.e - y_q.e;
          res_d.m    = iu_rsp_i.lo;
          state_d    = S_DONE;
        end
      end

      S_DONE: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (al_wr) begin
      x_d = swp_q ? b_n : a_n;
      y_d = swp_q ? a_n : b_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    x_q    <= x_d;
    y_q    <= y_d;
    swp_q  <= swp_d;
    pinx_q <= pinx_d;
    res_q  <= res_d;
    code_q <= code_d;
  end

  assign idle_o            = state_q == S_IDLE;
  assign done_o            = state_q == S_DONE;
  assign res_o.res_sign    = res_q.sign;
  assign res_o.res_inexact = res_q.inx;
  assign res_o.res_exp     = res_q.e;
  assign res_o.res_mant    = res_q.m;
  assign res_o.cmp_code    = code_q;

  a_start_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !idle_o |=> $stable(state_q) || state_q != S_IDLE)
    else $error("transaction offered while busy changed state");
  a_ack_leaves_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ack_i |=> idle_o) else $error("done not released on ack");
  a_no_unit_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o || (idle_o && !start_i)) |-> !iu_req_o.start)
    else $error("unit started with no work");

endmodule
